[hw/rtl/sfr_pkg.sv]
// shared types, constants and register indexes of the stream find and replace unit
// used by every module of the unit; depends on nothing
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int MAX_PATTERN     = 16;
    localparam int MAX_REPLACEMENT = 16;
    localparam int WIN_BYTES       = 16;
    localparam int WIN_W           = WIN_BYTES * 8;
    localparam int CNT_W           = $clog2(WIN_BYTES + 1);
    localparam int IDX_W           = $clog2(WIN_BYTES);
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int LEN_W           = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LEN  = 3'd5;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_last;
    } t_out_word;

    typedef struct packed {
        logic [63:0]      pattern_low;
        logic [63:0]      pattern_high;
        logic [LEN_W-1:0] pattern_length;
        logic [63:0]      replacement_low;
        logic [63:0]      replacement_high;
        logic [LEN_W-1:0] replacement_length;
    } t_cfg;

    // bytes to emit, oldest in the low byte
    typedef struct packed {
        logic [WIN_W-1:0] data;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_cmd;

endpackage

[hw/rtl/stream_find_and_replace_unit.sv]
// top level of the stream find and replace unit: configuration registers, scanner,
// command queue and emitter; depends on sfr_pkg, sfr_front, sfr_queue, sfr_back
`timescale 1ns / 1ps

// Bytes enter and leave one per cycle unless the input or the output channel stalls.
// An input word that resolves n output words (a replacement of n bytes, a flush of the
// window at the end of the stream, or the catch-up after a shorter pattern length)
// makes one command; the scanner keeps taking input until the two-entry command queue
// between it and the emitter is full, and then stalls. The emitter's single byte per
// cycle sets the sustained rate unless the output stalls. A pattern of 1 to 16 bytes
// and a replacement of 0 to 16 bytes are set through the configuration port, which is
// always ready and must be written only while the unit is idle, which is not enforced.

module stream_find_and_replace_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sfr_pkg::t_in_word                   i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sfr_pkg::t_out_word                  o_out_word
);

    sfr_pkg::t_cfg r_cfg;
    sfr_pkg::t_cmd w_push_cmd;
    sfr_pkg::t_cmd w_head;
    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_low        <= '0;
            r_cfg.pattern_high       <= '0;
            r_cfg.pattern_length     <= sfr_pkg::LEN_W'(1);
            r_cfg.replacement_low    <= '0;
            r_cfg.replacement_high   <= '0;
            r_cfg.replacement_length <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sfr_pkg::CFG_PATTERN_LOW:      r_cfg.pattern_low      <= i_cfg_data;
                sfr_pkg::CFG_PATTERN_HIGH:     r_cfg.pattern_high     <= i_cfg_data;
                sfr_pkg::CFG_PATTERN_LENGTH: begin
                    r_cfg.pattern_length <= i_cfg_data[sfr_pkg::LEN_W-1:0];
                end
                sfr_pkg::CFG_REPLACEMENT_LOW:  r_cfg.replacement_low  <= i_cfg_data;
                sfr_pkg::CFG_REPLACEMENT_HIGH: r_cfg.replacement_high <= i_cfg_data;
                sfr_pkg::CFG_REPLACEMENT_LEN: begin
                    r_cfg.replacement_length <= i_cfg_data[sfr_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    sfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .i_full  (w_full),
        .o_stall (o_in_stall),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    sfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );

endmodule

[hw/rtl/sfr_front.sv]
// scanner: holds the byte window, matches it to the pattern and turns an input
// word into a command if it emits bytes or ends the stream; depends on sfr_pkg
`timescale 1ns / 1ps

module sfr_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sfr_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    input  sfr_pkg::t_in_word           i_word,
    input  logic                        i_full,
    output logic                        o_stall,
    output logic                        o_push,
    output sfr_pkg::t_cmd               o_cmd
);

    logic [sfr_pkg::WIN_W-1:0] r_win;
    logic [sfr_pkg::CNT_W-1:0] r_cnt;
    logic [sfr_pkg::WIN_W-1:0] n_win;
    logic [sfr_pkg::CNT_W-1:0] n_cnt;

    logic [sfr_pkg::WIN_W-1:0] w_ext;
    logic [sfr_pkg::WIN_W-1:0] w_pat;
    logic [sfr_pkg::CNT_W-1:0] w_c;
    logic [sfr_pkg::CNT_W-1:0] w_plen;
    logic [sfr_pkg::CNT_W-1:0] w_rlen;
    logic [sfr_pkg::CNT_W-1:0] w_pop;
    logic [sfr_pkg::CNT_W-1:0] w_emit;
    logic                      w_match;
    logic                      w_accept;

    assign w_pat = {i_cfg.pattern_high, i_cfg.pattern_low};

    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            w_plen = sfr_pkg::CNT_W'(1);
        end else if (i_cfg.pattern_length > sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN)) begin
            w_plen = sfr_pkg::CNT_W'(sfr_pkg::MAX_PATTERN);
        end else begin
            w_plen = sfr_pkg::CNT_W'(i_cfg.pattern_length);
        end
        if (i_cfg.replacement_length > sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACEMENT)) begin
            w_rlen = sfr_pkg::CNT_W'(sfr_pkg::MAX_REPLACEMENT);
        end else begin
            w_rlen = sfr_pkg::CNT_W'(i_cfg.replacement_length);
        end
    end

    // window with the new byte appended
    always_comb begin
        w_ext = r_win;
        for (int i = 0; i < sfr_pkg::WIN_BYTES; i++) begin
            if (sfr_pkg::CNT_W'(i) == r_cnt) begin
                w_ext[i*8 +: 8] = i_word.in_byte;
            end
        end
    end

    assign w_c = r_cnt + sfr_pkg::CNT_W'(1);

    always_comb begin
        w_match = (w_c == w_plen);
        for (int i = 0; i < sfr_pkg::WIN_BYTES; i++) begin
            if ((sfr_pkg::CNT_W'(i) < w_plen) && (w_ext[i*8 +: 8] != w_pat[i*8 +: 8])) begin
                w_match = 1'b0;
            end
        end
    end

    always_comb begin
        if (w_match) begin
            w_pop = '0;
        end else if (i_word.in_last) begin
            w_pop = w_c;
        end else if (w_c > w_plen) begin
            w_pop = w_c - w_plen + sfr_pkg::CNT_W'(1);
        end else if (w_c == w_plen) begin
            w_pop = sfr_pkg::CNT_W'(1);
        end else begin
            w_pop = '0;
        end
    end

    assign w_emit   = w_match ? w_rlen : w_pop;
    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept && ((w_emit != '0) || i_word.in_last);

    always_comb begin
        o_cmd.data  = w_match ? {i_cfg.replacement_high, i_cfg.replacement_low} : w_ext;
        o_cmd.count = w_emit;
        o_cmd.last  = i_word.in_last;
    end

    always_comb begin
        n_win = r_win;
        n_cnt = r_cnt;
        if (w_accept) begin
            n_win = w_ext >> {w_pop, 3'b000};
            n_cnt = w_match ? '0 : (w_c - w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

[hw/rtl/sfr_queue.sv]
// two-entry command queue between the scanner and the emitter
// depends on sfr_pkg
`timescale 1ns / 1ps

module sfr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sfr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output sfr_pkg::t_cmd o_head
);

    sfr_pkg::t_cmd r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_fill;
    logic [1:0]    n_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_fill = r_fill;
        if (i_push && !i_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_fill <= n_fill;
        end
    end

endmodule

[hw/rtl/sfr_back.sv]
// emitter: walks the head command into the output register one byte a cycle
// while the output is not stalled; depends on sfr_pkg
`timescale 1ns / 1ps

module sfr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  sfr_pkg::t_cmd      i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output sfr_pkg::t_out_word o_word
);

    logic [sfr_pkg::IDX_W-1:0] r_idx;
    logic [sfr_pkg::IDX_W-1:0] n_idx;
    logic                      r_valid;
    logic                      n_valid;
    sfr_pkg::t_out_word        r_word;
    sfr_pkg::t_out_word        n_word;

    logic w_load;
    logic w_end;
    logic w_marker;

    assign w_load   = !r_valid || !i_stall;
    assign w_marker = (i_head.count == '0);
    assign w_end    = w_marker
                   || ((sfr_pkg::CNT_W'(r_idx) + sfr_pkg::CNT_W'(1)) == i_head.count);
    assign o_pop    = w_load && !i_empty && w_end;

    always_comb begin
        n_valid = r_valid;
        n_word  = r_word;
        n_idx   = r_idx;
        if (w_load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                if (w_marker) begin
                    n_word.out_byte = 8'd0;
                    n_word.has_byte = 1'b0;
                    n_word.out_last = 1'b1;
                end else begin
                    n_word.out_byte = i_head.data[r_idx*8 +: 8];
                    n_word.has_byte = 1'b1;
                    n_word.out_last = i_head.last && w_end;
                end
                n_idx = w_end ? '0 : (r_idx + sfr_pkg::IDX_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

[sim/tb_stream_find_and_replace_unit.sv]
// testbench of stream_find_and_replace_unit: a short directed table, then random phases of
// settings and byte streams, every output word checked against the table or a byte-level
// predictor; depends on sfr_pkg and stream_find_and_replace_unit
`timescale 1ns / 1ps

module tb_stream_find_and_replace_unit;

    localparam int ITEMS_WANTED = 400;
    localparam int HOLD_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SCRIPT_ROWS  = 28;

    typedef enum logic {ROW_REG, ROW_BYTE} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [2:0]           reg_idx;
        logic [63:0]          reg_val;
        sfr_pkg::t_in_word    word;
        bit                   typed;
        sfr_pkg::t_out_word   want;
    } t_script_row;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                           i_in_valid  = 1'b0;
    sfr_pkg::t_in_word              i_in_word   = '0;
    logic                           i_out_stall = 1'b0;
    logic                           o_cfg_ready;
    logic                           o_in_stall;
    logic                           o_out_valid;
    sfr_pkg::t_out_word             o_out_word;

    // predictor copy of the registers and the window
    logic [63:0]               pat_lo    = '0;
    logic [63:0]               pat_hi    = '0;
    logic [sfr_pkg::LEN_W-1:0] pat_len_r = 5'd1;
    logic [63:0]               rep_lo    = '0;
    logic [63:0]               rep_hi    = '0;
    logic [sfr_pkg::LEN_W-1:0] rep_len_r = '0;
    logic [7:0]                held_bytes [sfr_pkg::WIN_BYTES];
    int                        held_count = 0;

    sfr_pkg::t_out_word step_words [$];
    sfr_pkg::t_out_word pending_words [$];
    sfr_pkg::t_out_word seen_want;
    t_script_row        script [SCRIPT_ROWS];

    bit src_calm  = 1'b0;
    bit sink_calm = 1'b0;
    int stall_left = 0;
    int stall_roll;
    int cycle_count = 0;
    int items_sent = 0;
    int words_checked = 0;
    int replacements = 0;
    int settings_used = 0;
    int fail_count = 0;

    stream_find_and_replace_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] byte_at(logic [63:0] lo, logic [63:0] hi, int idx);
        logic [63:0] w;
        w = (idx < 8) ? lo : hi;
        return w[(idx % 8) * 8 +: 8];
    endfunction

    function automatic logic [7:0] take_oldest();
        logic [7:0] b;
        b = held_bytes[0];
        for (int k = 1; k < sfr_pkg::WIN_BYTES; k++) held_bytes[k-1] = held_bytes[k];
        if (held_count > 0) held_count--;
        return b;
    endfunction

    function automatic void give_byte(logic [7:0] b);
        step_words.push_back(sfr_pkg::t_out_word'{out_byte: b, has_byte: 1'b1,
                                                  out_last: 1'b0});
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [63:0] val);
        case (idx)
            sfr_pkg::CFG_PATTERN_LOW:      pat_lo = val;
            sfr_pkg::CFG_PATTERN_HIGH:     pat_hi = val;
            sfr_pkg::CFG_PATTERN_LENGTH:   pat_len_r = val[sfr_pkg::LEN_W-1:0];
            sfr_pkg::CFG_REPLACEMENT_LOW:  rep_lo = val;
            sfr_pkg::CFG_REPLACEMENT_HIGH: rep_hi = val;
            sfr_pkg::CFG_REPLACEMENT_LEN:  rep_len_r = val[sfr_pkg::LEN_W-1:0];
            default: ;
        endcase
    endfunction

    // output words caused by one input word, left in step_words
    function automatic void scan_byte(logic [7:0] b, logic last);
        int plen;
        int rlen;
        int k;
        bit hit;
        step_words.delete();
        plen = (pat_len_r == 0) ? 1 :
               ((pat_len_r > sfr_pkg::MAX_PATTERN) ? sfr_pkg::MAX_PATTERN : pat_len_r);
        rlen = (rep_len_r > sfr_pkg::MAX_REPLACEMENT) ? sfr_pkg::MAX_REPLACEMENT : rep_len_r;
        if (held_count >= sfr_pkg::WIN_BYTES) give_byte(take_oldest());
        held_bytes[4'(held_count % sfr_pkg::WIN_BYTES)] = b;
        held_count++;
        if (held_count > plen) begin
            while (held_count + 1 > plen && held_count > 0) give_byte(take_oldest());
        end else if (held_count == plen) begin
            hit = 1'b1;
            for (k = 0; k < plen; k++) begin
                if (held_bytes[k] != byte_at(pat_lo, pat_hi, k)) hit = 1'b0;
            end
            if (hit) begin
                for (k = 0; k < rlen; k++) give_byte(byte_at(rep_lo, rep_hi, k));
                held_count = 0;
                replacements++;
            end else begin
                give_byte(take_oldest());
            end
        end
        if (last) begin
            while (held_count > 0) give_byte(take_oldest());
            if (step_words.size() == 0) begin
                step_words.push_back(sfr_pkg::t_out_word'{out_byte: 8'h00, has_byte: 1'b0,
                                                          out_last: 1'b0});
            end
            step_words[step_words.size()-1].out_last = 1'b1;
        end
    endfunction

    function automatic t_script_row reg_row(logic [2:0] idx, logic [63:0] val);
        t_script_row row;
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        row.word    = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic t_script_row word_row(logic [7:0] b, logic last);
        t_script_row row;
        row      = reg_row(sfr_pkg::CFG_PATTERN_LOW, '0);
        row.kind = ROW_BYTE;
        row.word = sfr_pkg::t_in_word'{in_byte: b, in_last: last};
        return row;
    endfunction

    function automatic t_script_row known_row(logic [7:0] b, logic last, logic [7:0] ob,
                                              logic has, logic ol);
        t_script_row row;
        row       = word_row(b, last);
        row.typed = 1'b1;
        row.want  = sfr_pkg::t_out_word'{out_byte: ob, has_byte: has, out_last: ol};
        return row;
    endfunction

    function automatic int pick_gap();
        int r;
        if (src_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_word(logic [7:0] b, logic last, bit typed,
                             sfr_pkg::t_out_word want);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= sfr_pkg::t_in_word'{in_byte: b, in_last: last};
        do @(posedge i_clk); while (o_in_stall);
        scan_byte(b, last);
        if (typed) begin
            pending_words.push_back(want);
        end else begin
            foreach (step_words[k]) pending_words.push_back(step_words[k]);
        end
        items_sent++;
    endtask

    // hold the sender until every expected word is out and the pipeline has settled
    task automatic wait_quiet();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (HOLD_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] length_value(int len);
        logic [63:0] v;
        v = ($urandom_range(0, 1) == 0) ? 64'd0 : {$urandom, $urandom};
        v[sfr_pkg::LEN_W-1:0] = len[sfr_pkg::LEN_W-1:0];
        return v;
    endfunction

    task automatic run_phase();
        logic [7:0]   pat [16];
        logic [127:0] pat_bits;
        logic [7:0]   text [$];
        int plen_code;
        int rlen_code;
        int plen;
        int len;
        int r;
        int k;
        int cut;
        bit two_letters;
        bit moved;
        src_calm  = ($urandom_range(0, 3) == 0);
        sink_calm = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 8)       plen_code = 0;
        else if (r < 14) plen_code = $urandom_range(17, 31);
        else if (r < 26) plen_code = 16;
        else             plen_code = $urandom_range(1, 5);
        plen = (plen_code == 0) ? 1 : ((plen_code > 16) ? 16 : plen_code);
        r = $urandom_range(0, 99);
        if (r < 10)      rlen_code = 0;
        else if (r < 18) rlen_code = $urandom_range(17, 31);
        else if (r < 28) rlen_code = 16;
        else             rlen_code = $urandom_range(1, 6);
        two_letters = 1'($urandom_range(0, 1));
        for (k = 0; k < 16; k++) begin
            pat[k] = two_letters ? 8'(8'h61 + $urandom_range(0, 1)) : 8'($urandom);
            pat_bits[k*8 +: 8] = pat[k];
        end

        wait_quiet();
        write_reg(sfr_pkg::CFG_PATTERN_LOW, pat_bits[63:0]);
        write_reg(sfr_pkg::CFG_PATTERN_HIGH, pat_bits[127:64]);
        write_reg(sfr_pkg::CFG_PATTERN_LENGTH, length_value(plen_code));
        write_reg(sfr_pkg::CFG_REPLACEMENT_LOW, {$urandom, $urandom});
        write_reg(sfr_pkg::CFG_REPLACEMENT_HIGH, {$urandom, $urandom});
        write_reg(sfr_pkg::CFG_REPLACEMENT_LEN, length_value(rlen_code));
        settings_used++;

        repeat ($urandom_range(1, 4)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
            text.delete();
            while (text.size() < len) begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    for (k = 0; k < plen; k++) text.push_back(pat[k]);
                end else if (r < 50) begin
                    cut = $urandom_range(0, plen - 1);
                    for (k = 0; k < cut; k++) text.push_back(pat[k]);
                    text.push_back(8'($urandom));
                end else if (r < 75) begin
                    text.push_back(pat[$urandom_range(0, plen - 1)]);
                end else begin
                    text.push_back(8'($urandom));
                end
            end
            moved = 1'b0;
            for (k = 0; k < text.size(); k++) begin
                // pattern length moved while bytes sit in the window
                if (k > 0 && $urandom_range(0, 39) == 0) begin
                    wait_quiet();
                    write_reg(sfr_pkg::CFG_PATTERN_LENGTH, 64'($urandom_range(0, plen)));
                    moved = 1'b1;
                end
                send_word(text[k], k == text.size() - 1, 1'b0, '0);
            end
            if (moved) begin
                wait_quiet();
                write_reg(sfr_pkg::CFG_PATTERN_LENGTH, 64'(plen_code));
            end
        end
    endtask

    task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(negedge i_clk) begin
        if (sink_calm) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 55) begin
                i_out_stall <= 1'b0;
            end else if (stall_roll < 92) begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(5, 30);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $display("%0t ns: word with none expected, got %p", $time, o_out_word);
                fail_count++;
            end else begin
                seen_want = pending_words.pop_front();
                check_field("out_byte", seen_want.out_byte, o_out_word.out_byte);
                check_field("has_byte", {7'd0, seen_want.has_byte},
                            {7'd0, o_out_word.has_byte});
                check_field("out_last", {7'd0, seen_want.out_last},
                            {7'd0, o_out_word.out_last});
                words_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d words still due",
                     cycle_count, pending_words.size());
            $display("stream_find_and_replace_unit: mismatch");
            $finish;
        end
    end

    initial begin
        int i;
        int directed_items;
        bit prev_reg;
        script = '{
            known_row(8'h00, 1'b1, 8'h00, 1'b0, 1'b1),
            known_row(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1),
            reg_row(sfr_pkg::CFG_PATTERN_LOW, 64'h0000_0000_0000_00AB),
            reg_row(sfr_pkg::CFG_PATTERN_LENGTH, 64'd0),
            reg_row(sfr_pkg::CFG_REPLACEMENT_LOW, 64'h0123_4567_89AB_CDEF),
            reg_row(sfr_pkg::CFG_REPLACEMENT_HIGH, 64'hFEDC_BA98_7654_3210),
            reg_row(sfr_pkg::CFG_REPLACEMENT_LEN, 64'd31),
            word_row(8'hAB, 1'b0),
            known_row(8'h00, 1'b0, 8'h00, 1'b1, 1'b0),
            word_row(8'hAB, 1'b1),
            reg_row(sfr_pkg::CFG_PATTERN_HIGH, '1),
            reg_row(sfr_pkg::CFG_PATTERN_LOW, '1),
            reg_row(sfr_pkg::CFG_PATTERN_LENGTH, 64'd31),
            reg_row(sfr_pkg::CFG_REPLACEMENT_LEN, 64'd0),
            word_row(8'hFF, 1'b0),
            word_row(8'hFF, 1'b0),
            word_row(8'hFF, 1'b0),
            word_row(8'hFF, 1'b0),
            word_row(8'hFF, 1'b0),
            word_row(8'hFF, 1'b0),
            word_row(8'hFF, 1'b0),
            word_row(8'hFF, 1'b0),
            reg_row(sfr_pkg::CFG_PATTERN_LENGTH, 64'd2),
            word_row(8'hFF, 1'b0),
            known_row(8'hFF, 1'b1, 8'h00, 1'b0, 1'b1),
            reg_row(sfr_pkg::CFG_PATTERN_LENGTH, 64'd1),
            known_row(8'h7E, 1'b1, 8'h7E, 1'b1, 1'b1),
            known_row(8'h81, 1'b1, 8'h81, 1'b1, 1'b1)
        };
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        prev_reg = 1'b0;
        for (i = 0; i < SCRIPT_ROWS; i++) begin
            if (script[i].kind == ROW_REG) begin
                if (!prev_reg) wait_quiet();
                write_reg(script[i].reg_idx, script[i].reg_val);
                prev_reg = 1'b1;
            end else begin
                send_word(script[i].word.in_byte, script[i].word.in_last,
                          script[i].typed, script[i].want);
                prev_reg = 1'b0;
            end
        end
        settings_used = 4;

        directed_items = items_sent;
        while (items_sent - directed_items < ITEMS_WANTED) run_phase();
        wait_quiet();

        $display("sent %0d input words under %0d register settings, %0d pattern hits",
                 items_sent, settings_used, replacements);
        $display("checked %0d output words, %0d still due", words_checked,
                 pending_words.size());
        if (fail_count == 0 && pending_words.size() == 0) begin
            $display("stream_find_and_replace_unit: match");
        end else begin
            $display("stream_find_and_replace_unit: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_front.sv
hw/rtl/sfr_queue.sv
hw/rtl/sfr_back.sv
hw/rtl/stream_find_and_replace_unit.sv
sim/tb_stream_find_and_replace_unit.sv
